[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the median deviation unit.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define SWMD_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition leads to another one in the next cycle
`define SWMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swmd_pkg.sv]
// Shared types and constants of the sliding window median deviation unit.
// Depends on nothing.
package swmd_pkg;

    localparam int MAX_WINDOW_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_W            = 9;
    localparam int IN_W             = 32;
    localparam int COST_W           = 40;

    // Operation broadcast to every cell of the sorted row
    typedef struct packed {
        logic ins;
        logic del;
    } cell_cmd_t;

endpackage

[rtl/swmd_cell.sv]
// One cell of the sorted row: holds a sample and shifts with its neighbors.
// Depends on swmd_pkg.
module swmd_cell #(
    parameter int W = swmd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    clk,
    input  swmd_pkg::cell_cmd_t     cmd,
    input  logic signed [W-1:0]     key,
    input  logic                    valid,
    input  logic [W-1:0]            left_val,
    input  logic                    left_flag,
    input  logic [W-1:0]            right_val,
    output logic [W-1:0]            val,
    output logic                    flag
);

    logic [W-1:0] val_reg;
    logic [W-1:0] val_next;

    // Mark cells at or past the insert or delete point; empty cells count as past
    always_comb
    begin
        if (!valid)
            flag = 1'b1;
        else if (cmd.ins)
            flag = ($signed(val_reg) > key);
        else
            flag = ($signed(val_reg) >= key);
    end

    // Shift right on insert, left on delete
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && flag)
            val_next = left_flag ? left_val : key;
        else if (cmd.del && flag)
            val_next = right_val;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/swmd_chain.sv]
// Row of sorted cells that inserts or deletes one sample per cycle.
// Depends on swmd_pkg and swmd_cell.
module swmd_chain #(
    parameter int MAX_WINDOW   = swmd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swmd_pkg::SAMPLE_WIDTH_DEF,
    parameter int KW           = $clog2(MAX_WINDOW + 1)
) (
    input  logic                                 clk,
    input  swmd_pkg::cell_cmd_t                  cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]       key,
    input  logic [KW-1:0]                        fill,
    output logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] vals,
    output logic [MAX_WINDOW-1:0]                flags
);

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            logic [SAMPLE_WIDTH-1:0] lv;
            logic [SAMPLE_WIDTH-1:0] rv;
            logic                    lf;

            // Tie the row ends to the cell itself
            if (i == 0)
            begin : g_first
                assign lv = vals[i];
                assign lf = 1'b0;
            end
            else
            begin : g_mid
                assign lv = vals[i-1];
                assign lf = flags[i-1];
            end
            if (i == MAX_WINDOW - 1)
            begin : g_last
                assign rv = vals[i];
            end
            else
            begin : g_inner
                assign rv = vals[i+1];
            end

            swmd_cell #(
                .W (SAMPLE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .key       (key),
                .valid     (fill > KW'(i)),
                .left_val  (lv),
                .left_flag (lf),
                .right_val (rv),
                .val       (vals[i]),
                .flag      (flags[i])
            );
        end
    endgenerate

endmodule

[rtl/sliding_window_median_deviation_unit.sv]
// Top level of the sliding window median deviation unit: control, ring, sums.
// Depends on swmd_pkg, swmd_chain, assert_macros.svh.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata[31:0] sample
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata[39:0] deviation_cost
//  cfg       in   cfg_wr_en                      cfg_wr_data[8:0] window_size
//
// A word that does not fill the window is accepted, then inserted.
// A word that fills it goes through insert, median pick, multiply, cost, delete.
// The cell row does one insert or one delete a cycle; a new word waits for idle.
// A result waits in the output register while the next word is accepted;
// the cost step stalls only while that register is still full.
// Reset empties the window; no clearing pass is needed.
`include "assert_macros.svh"

module sliding_window_median_deviation_unit #(
    parameter int MAX_WINDOW   = swmd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swmd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [swmd_pkg::IN_W-1:0]   s_axis_tdata,   // [31:0] sample
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [swmd_pkg::COST_W-1:0] m_axis_tdata,   // [39:0] deviation_cost
    input  logic                        cfg_wr_en,
    input  logic [swmd_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W = SAMPLE_WIDTH + KW;
    localparam int PW    = SAMPLE_WIDTH + KW + 1;
    localparam int CW    = SUM_W + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_MED  = 3'd2;
    localparam logic [2:0] S_PROD = 3'd3;
    localparam logic [2:0] S_COST = 3'd4;
    localparam logic [2:0] S_REM  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [swmd_pkg::CFG_W-1:0]     ws_reg;
    logic [KW-1:0]                  fill_reg, fill_next;
    logic [AW-1:0]                  rp_reg, rp_next;
    logic signed [SUM_W-1:0]        lower_reg, lower_next;
    logic signed [SUM_W-1:0]        upper_reg, upper_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [SAMPLE_WIDTH-1:0]        rd_reg;
    logic                           byp_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_reg;
    logic signed [PW-1:0]           plo_reg, pup_reg;
    logic                           out_valid_reg;
    logic [swmd_pkg::COST_W-1:0]    out_data_reg;

    logic [SAMPLE_WIDTH-1:0]        ring [MAX_WINDOW];

    logic [KW-1:0]                  k_eff, lc, uc;
    logic [AW-1:0]                  old_addr;
    logic [KW:0]                    back;
    logic                           in_acc, out_free, cost_done;
    swmd_pkg::cell_cmd_t            cmd;
    logic signed [SAMPLE_WIDTH-1:0] key, rem_val;
    logic [MAX_WINDOW-1:0][SAMPLE_WIDTH-1:0] vals;
    logic [MAX_WINDOW-1:0]          flags;
    logic [SAMPLE_WIDTH-1:0]        med_val, up_val;
    logic                           med_flag;
    logic signed [SUM_W-1:0]        xs, meds, ups, rs;
    logic signed [CW-1:0]           cost;

    // Clamp the window size to 1..MAX_WINDOW
    always_comb
    begin
        if (ws_reg == '0)
            k_eff = KW'(1);
        else if (32'(ws_reg) > MAX_WINDOW)
            k_eff = KW'(MAX_WINDOW);
        else
            k_eff = KW'(ws_reg);
        lc = KW'(((KW+1)'(k_eff) + (KW+1)'(1)) >> 1);
        uc = k_eff >> 1;
    end

    // Locate the oldest sample of the window in the ring
    always_comb
    begin
        back = (KW+1)'(k_eff) - (KW+1)'(1);
        if ((KW+1)'(rp_reg) >= back)
            old_addr = AW'((KW+1)'(rp_reg) - back);
        else
            old_addr = AW'((KW+1)'(rp_reg) + (KW+1)'(MAX_WINDOW) - back);
    end

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cost_done = (state_reg == S_COST) && out_free && !cfg_wr_en;
    assign rem_val   = byp_reg ? x_reg : $signed(rd_reg);

    // Drive the cell row
    always_comb
    begin
        cmd.ins = (state_reg == S_INS);
        cmd.del = (state_reg == S_REM);
        key     = (state_reg == S_REM) ? rem_val : x_reg;
    end

    swmd_chain #(
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .KW           (KW)
    ) u_chain (
        .clk   (clk),
        .cmd   (cmd),
        .key   (key),
        .fill  (fill_reg),
        .vals  (vals),
        .flags (flags)
    );

    // Pick the median cell and the first upper cell
    always_comb
    begin
        med_val  = '0;
        med_flag = 1'b0;
        up_val   = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (KW'(i) == lc - KW'(1))
            begin
                med_val  = vals[i];
                med_flag = flags[i];
            end
            if (KW'(i) == lc)
                up_val = vals[i];
        end
    end

    // Update the half sums as a sample enters or leaves
    always_comb
    begin
        xs         = SUM_W'(x_reg);
        meds       = SUM_W'($signed(med_val));
        ups        = SUM_W'($signed(up_val));
        rs         = SUM_W'(rem_val);
        lower_next = lower_reg;
        upper_next = upper_reg;
        if (state_reg == S_INS)
        begin
            if (med_flag)
            begin
                if (fill_reg >= lc)
                begin
                    lower_next = lower_reg + xs - meds;
                    upper_next = upper_reg + meds;
                end
                else
                begin
                    lower_next = lower_reg + xs;
                end
            end
            else
            begin
                upper_next = upper_reg + xs;
            end
        end
        else if (state_reg == S_REM)
        begin
            if (med_flag)
            begin
                if (lc < fill_reg)
                begin
                    lower_next = lower_reg - rs + ups;
                    upper_next = upper_reg - ups;
                end
                else
                begin
                    lower_next = lower_reg - rs;
                end
            end
            else
            begin
                upper_next = upper_reg - rs;
            end
        end
    end

    assign cost = CW'(plo_reg) - CW'(lower_reg) + CW'(upper_reg) - CW'(pup_reg);

    // Sequence one word through insert and, once the window is full, median pick, multiply, cost and delete
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        rp_next    = rp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_INS;
            end
            S_INS:
            begin
                fill_next = fill_reg + KW'(1);
                if (fill_next < k_eff)
                begin
                    rp_next    = (rp_reg == AW'(MAX_WINDOW - 1)) ? '0 : rp_reg + AW'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MED;
                end
            end
            S_MED:  state_next = S_PROD;
            S_PROD: state_next = S_COST;
            S_COST:
            begin
                if (out_free)
                    state_next = S_REM;
            end
            S_REM:
            begin
                fill_next  = fill_reg - KW'(1);
                rp_next    = (rp_reg == AW'(MAX_WINDOW - 1)) ? '0 : rp_reg + AW'(1);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control state; a config write empties the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= swmd_pkg::CFG_W'(1);
            fill_reg      <= '0;
            rp_reg        <= '0;
            lower_reg     <= '0;
            upper_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ws_reg    <= cfg_wr_data;
                state_reg <= S_IDLE;
                fill_reg  <= '0;
                rp_reg    <= '0;
                lower_reg <= '0;
                upper_reg <= '0;
            end
            else
            begin
                state_reg <= state_next;
                fill_reg  <= fill_next;
                rp_reg    <= rp_next;
                lower_reg <= lower_next;
                upper_reg <= upper_next;
            end
            if (cost_done)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the word, write the ring, fetch the oldest sample
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg        <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
            ring[rp_reg] <= s_axis_tdata[SAMPLE_WIDTH-1:0];
            rd_reg       <= ring[old_addr];
            byp_reg      <= (old_addr == rp_reg);
        end
    end

    // Hold the median, its products and the result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MED)
            m_reg <= $signed(med_val);
        if (state_reg == S_PROD)
        begin
            plo_reg <= $signed({1'b0, lc}) * m_reg;
            pup_reg <= $signed({1'b0, uc}) * m_reg;
        end
        if (state_reg == S_COST && out_free)
            out_data_reg <= swmd_pkg::COST_W'(cost);
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SWMD_ASSERT(a_fill_le_k, fill_reg <= k_eff, "fill count exceeds window size")
    `SWMD_ASSERT(a_idle_not_full, (state_reg != S_IDLE) || (fill_reg < k_eff), "full while idle")
    `SWMD_ASSERT_NEXT(a_cost_lands, cost_done, m_axis_tvalid, "result not presented")

endmodule
